FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next cycle.
`define HHD_ASSERT_NEXT(label, ante, cons, msg) \
  `HHD_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/hhd_pkg.sv
// Types, codes and helpers for the HCI H4 receive deframer.
`default_nettype none

package hhd_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRE  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  // Result kind.
  typedef enum logic [1:0] {
    KIND_TYPE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  // H4 packet type codes.
  localparam logic [2:0] PKT_NONE = 3'd0;
  localparam logic [2:0] PKT_CMD  = 3'd1;
  localparam logic [2:0] PKT_ACL  = 3'd2;
  localparam logic [2:0] PKT_SCO  = 3'd3;
  localparam logic [2:0] PKT_EVT  = 3'd4;

  // Preamble byte counts per type.
  localparam logic [2:0] PRE_CMD = 3'd3;
  localparam logic [2:0] PRE_ACL = 3'd4;
  localparam logic [2:0] PRE_SCO = 3'd3;
  localparam logic [2:0] PRE_EVT = 3'd2;

  // Offset within preamble plus payload.
  localparam int unsigned OffW = 17;
  // Offset where the ACL length low byte sits.
  localparam logic [OffW-1:0] AclLenLoOff = 17'd2;

  // One result transaction.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       out_byte;
    logic [2:0]       packet_type;
    logic [OffW-1:0]  byte_offset;
    logic             is_last;
    logic [OffW-1:0]  total_length;
  } hhd_result_t;

  // Preamble length for a valid type code.
  function automatic logic [2:0] pre_size(input logic [2:0] ptype);
    logic [2:0] size;
    unique case (ptype)
      PKT_CMD: size = PRE_CMD;
      PKT_ACL: size = PRE_ACL;
      PKT_SCO: size = PRE_SCO;
      PKT_EVT: size = PRE_EVT;
      default: size = 3'd0;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hhd_in_if.sv
// Byte input channel of the deframer.
`default_nettype none

interface hhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hhd_out_if.sv
// Result output channel of the deframer.
`default_nettype none

interface hhd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [2:0]  packet_type;
  logic [16:0] byte_offset;
  logic        is_last;
  logic [16:0] total_length;

  modport source (output valid, output kind, output out_byte, output packet_type,
                  output byte_offset, output is_last, output total_length,
                  input ready);
  modport sink (input valid, input kind, input out_byte, input packet_type,
                input byte_offset, input is_last, input total_length,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hci_h4_uart_packet_deframer_unit.sv
// HCI H4 UART receive deframer, top level.
//
// in_i carries one received UART byte per transaction; out_o returns exactly
// one result per accepted byte: type byte accepted, packet byte (with type,
// offset, last flag and total length on the final byte) or bad type dropped.
// Both channels use valid/ready; a transaction completes when both are high.
//
// Latency: the result of a byte appears on out_o in the cycle after it is
// accepted. Throughput: one byte per cycle while out_o is not stalled,
// set by the single parser update between byte input and result register.
//
// The result register holds one transaction. While out_o is stalled with a
// result pending, in_i.ready drops and nothing is lost; a byte is taken again
// in the same cycle that the pending result is taken.
//
// Reset clears the parser to idle (awaiting a type byte) and empties the
// result register; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module hci_h4_uart_packet_deframer_unit
  import hhd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hhd_in_if.sink      in_i,
  hhd_out_if.source   out_o
);

  hhd_result_t res;
  hhd_result_t res_q;
  logic        valid_q;
  logic        step;

  // Accept a byte when the result register is free or being drained.
  assign in_i.ready = !valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  hhd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_i.rx_byte),
    .res_o     (res)
  );

  // Track result register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Load the result payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.packet_type  = res_q.packet_type;
  assign out_o.byte_offset  = res_q.byte_offset;
  assign out_o.is_last      = res_q.is_last;
  assign out_o.total_length = res_q.total_length;

  `HHD_ASSERT(a_ready_when_empty, !valid_q |-> in_i.ready,
              "input stalled while result register empty")
  `HHD_ASSERT_NEXT(a_step_fills, step, valid_q,
                   "accepted byte produced no result")
  `HHD_ASSERT_NEXT(a_hold_stalled_result, out_o.valid && !out_o.ready,
                   out_o.valid && $stable(res_q), "stalled result changed")

endmodule

`default_nettype wire

FILE: rtl/core/hhd_parser.sv
// H4 packet parser: state registers and per-byte result logic.
`default_nettype none
`include "assert_macros.svh"

module hhd_parser
  import hhd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  rx_byte_i,
  output hhd_result_t      res_o
);

  phase_e           phase_q, phase_d;
  logic [2:0]       type_q, type_d;
  logic [15:0]      remain_q, remain_d;
  logic [7:0]       acl_lo_q, acl_lo_d;
  logic [OffW-1:0]  offset_q, offset_d;
  logic [2:0]       pre_q, pre_d;

  logic [15:0]      remain_dec;
  logic [OffW-1:0]  offset_inc;
  logic [15:0]      pay_len;
  logic [7:0]       acl_lo_cur;

  // Hold state, advance only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      type_q   <= PKT_NONE;
      remain_q <= '0;
      acl_lo_q <= '0;
      offset_q <= '0;
      pre_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      remain_q <= remain_d;
      acl_lo_q <= acl_lo_d;
      offset_q <= offset_d;
      pre_q    <= pre_d;
    end
  end

  assign remain_dec = remain_q - 16'd1;
  assign offset_inc = offset_q + 17'd1;
  assign acl_lo_cur = (offset_q == AclLenLoOff) ? rx_byte_i : acl_lo_q;
  assign pay_len    = (type_q == PKT_ACL) ? {rx_byte_i, acl_lo_cur} : {8'd0, rx_byte_i};

  // Next state and result for the byte at the input.
  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    remain_d = remain_q;
    acl_lo_d = acl_lo_q;
    offset_d = offset_q;
    pre_d    = pre_q;

    res_o.kind         = KIND_BYTE;
    res_o.out_byte     = rx_byte_i;
    res_o.packet_type  = type_q;
    res_o.byte_offset  = offset_q;
    res_o.is_last      = 1'b0;
    res_o.total_length = '0;

    unique case (phase_q)
      PH_PRE: begin
        acl_lo_d = acl_lo_cur;
        offset_d = offset_inc;
        remain_d = remain_dec;
        if (remain_dec == 16'd0) begin
          if (pay_len == 16'd0) begin
            // Zero-length packet ends on its last preamble byte.
            phase_d            = PH_IDLE;
            res_o.is_last      = 1'b1;
            res_o.total_length = {14'd0, pre_q};
          end else begin
            remain_d = pay_len;
            phase_d  = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        offset_d = offset_inc;
        if (remain_q <= 16'd1) begin
          remain_d           = '0;
          phase_d            = PH_IDLE;
          res_o.is_last      = 1'b1;
          res_o.total_length = offset_inc;
        end else begin
          remain_d = remain_dec;
        end
      end
      default: begin
        // Idle, and the unused phase code behaves as idle.
        phase_d           = PH_IDLE;
        res_o.out_byte    = '0;
        res_o.byte_offset = '0;
        if (rx_byte_i >= 8'd1 && rx_byte_i <= 8'd4) begin
          type_d            = rx_byte_i[2:0];
          pre_d             = pre_size(rx_byte_i[2:0]);
          remain_d          = {13'd0, pre_size(rx_byte_i[2:0])};
          acl_lo_d          = '0;
          offset_d          = '0;
          phase_d           = PH_PRE;
          res_o.kind        = KIND_TYPE;
          res_o.packet_type = rx_byte_i[2:0];
        end else begin
          // Drop a bad type byte and stay idle.
          res_o.kind        = KIND_DROP;
          res_o.packet_type = PKT_NONE;
        end
      end
    endcase
  end

  `HHD_ASSERT_NEXT(a_last_goes_idle, step_i && res_o.is_last, phase_q == PH_IDLE,
                   "last byte did not return parser to idle")
  `HHD_ASSERT_NEXT(a_type_starts_pre, step_i && res_o.kind == KIND_TYPE,
                   phase_q == PH_PRE && offset_q == '0,
                   "type byte did not start a preamble at offset zero")
  `HHD_ASSERT_NEXT(a_offset_advances, step_i && res_o.kind == KIND_BYTE,
                   offset_q == OffW'($past(offset_q) + 17'd1),
                   "packet byte did not advance the offset")

endmodule

`default_nettype wire
